@@ hdl/sha1c_pkg.sv @@
// Types, constants and round functions shared by the SHA-1 compression pipeline.
package sha1c_pkg;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned ROUND_IDX_W = 7;

   localparam logic [31:0] K_CHOOSE = 32'h5A827999;
   localparam logic [31:0] K_PARITY_LO = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
   localparam logic [31:0] K_PARITY_HI = 32'hCA62C1D6;

   typedef struct packed {
      logic [63:0] words_00_01;
      logic [63:0] words_02_03;
      logic [63:0] words_04_05;
      logic [63:0] words_06_07;
      logic [63:0] words_08_09;
      logic [63:0] words_10_11;
      logic [63:0] words_12_13;
      logic [63:0] words_14_15;
      logic [63:0] chain_in_ab;
      logic [63:0] chain_in_cd;
      logic [31:0] chain_in_e;
   } req_word_type;

   typedef struct packed {
      logic [63:0] chain_out_ab;
      logic [63:0] chain_out_cd;
      logic [31:0] chain_out_e;
   } rsp_word_type;

   // One pipeline stage: working variables, the precomputed e + K + W term for
   // the coming round, the sixteen-word schedule window and the chaining input.
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
      logic [31:0] pre;
      logic [15:0][31:0] w;
      logic [4:0][31:0] h;
   } stage_type;

   function automatic logic [31:0] round_k(input logic [ROUND_IDX_W-1:0] idx);
      logic [31:0] k;
      case (idx) inside
         [7'd0:7'd19]:  k = K_CHOOSE;
         [7'd20:7'd39]: k = K_PARITY_LO;
         [7'd40:7'd59]: k = K_MAJORITY;
         default:       k = K_PARITY_HI;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] mix_fn(input logic [ROUND_IDX_W-1:0] idx,
                                          input logic [31:0] x,
                                          input logic [31:0] y,
                                          input logic [31:0] z);
      logic [31:0] f;
      case (idx) inside
         [7'd0:7'd19]:  f = z ^ (x & (y ^ z));
         [7'd40:7'd59]: f = (x & y) | (z & (x ^ y));
         default:       f = x ^ y ^ z;
      endcase
      return f;
   endfunction

endpackage

@@ hdl/sha1c_round.sv @@
// One registered SHA-1 round with its message schedule step.
module sha1c_round
   import sha1c_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic [ROUND_IDX_W-1:0] round_idx,
   input  logic                   valid_in,
   input  stage_type              stage_in,
   output logic                   valid_out,
   output stage_type              stage_out
);

   logic                   valid_ff;
   stage_type              stage_ff;
   stage_type              stage_in_nxt;
   logic [ROUND_IDX_W-1:0] next_idx;
   logic [31:0]            rot_a;
   logic [31:0]            sched_x;

   assign next_idx = round_idx + 7'd1;
   assign rot_a    = {stage_in.a[26:0], stage_in.a[31:27]};
   assign sched_x  = stage_in.w[13] ^ stage_in.w[8] ^ stage_in.w[2] ^ stage_in.w[0];

   always_comb begin
      stage_in_nxt   = stage_in;
      stage_in_nxt.a = rot_a + mix_fn(round_idx, stage_in.b, stage_in.c, stage_in.d)
                       + stage_in.pre;
      stage_in_nxt.b = stage_in.a;
      stage_in_nxt.c = {stage_in.b[1:0], stage_in.b[31:2]};
      stage_in_nxt.d = stage_in.c;
      stage_in_nxt.e = stage_in.d;
      // The next round's e is this round's d, so its sum can start now.
      stage_in_nxt.pre = stage_in.d + round_k(next_idx) + stage_in.w[1];
      for (int i = 0; i < 15; i++) begin
         stage_in_nxt.w[i] = stage_in.w[i+1];
      end
      stage_in_nxt.w[15] = {sched_x[30:0], sched_x[31]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in_nxt;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

@@ hdl/sha1_block_compress.sv @@
// Top level: fully pipelined SHA-1 compression, one round per stage.
// Throughput: one word per cycle; a stalled result freezes the whole pipeline.
// The stages are an entry register, 80 round registers and the output register behind the adder.
// Reset clears every valid bit; the data registers are not reset.
module sha1_block_compress
   import sha1c_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         advance;
   logic         stage_valid [0:ROUNDS];
   stage_type    stage_data  [0:ROUNDS];
   logic         entry_valid_ff;
   stage_type    entry_ff;
   stage_type    entry_in;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      entry_in.w[0]  = req_word.words_00_01[63:32];
      entry_in.w[1]  = req_word.words_00_01[31:0];
      entry_in.w[2]  = req_word.words_02_03[63:32];
      entry_in.w[3]  = req_word.words_02_03[31:0];
      entry_in.w[4]  = req_word.words_04_05[63:32];
      entry_in.w[5]  = req_word.words_04_05[31:0];
      entry_in.w[6]  = req_word.words_06_07[63:32];
      entry_in.w[7]  = req_word.words_06_07[31:0];
      entry_in.w[8]  = req_word.words_08_09[63:32];
      entry_in.w[9]  = req_word.words_08_09[31:0];
      entry_in.w[10] = req_word.words_10_11[63:32];
      entry_in.w[11] = req_word.words_10_11[31:0];
      entry_in.w[12] = req_word.words_12_13[63:32];
      entry_in.w[13] = req_word.words_12_13[31:0];
      entry_in.w[14] = req_word.words_14_15[63:32];
      entry_in.w[15] = req_word.words_14_15[31:0];
      entry_in.h[0]  = req_word.chain_in_ab[63:32];
      entry_in.h[1]  = req_word.chain_in_ab[31:0];
      entry_in.h[2]  = req_word.chain_in_cd[63:32];
      entry_in.h[3]  = req_word.chain_in_cd[31:0];
      entry_in.h[4]  = req_word.chain_in_e;
      entry_in.a     = entry_in.h[0];
      entry_in.b     = entry_in.h[1];
      entry_in.c     = entry_in.h[2];
      entry_in.d     = entry_in.h[3];
      entry_in.e     = entry_in.h[4];
      entry_in.pre   = entry_in.h[4] + K_CHOOSE + entry_in.w[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_data[0]  = entry_ff;

   for (genvar t = 0; t < ROUNDS; t++) begin : g_round
      sha1c_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_idx (ROUND_IDX_W'(t)),
         .valid_in  (stage_valid[t]),
         .stage_in  (stage_data[t]),
         .valid_out (stage_valid[t+1]),
         .stage_out (stage_data[t+1])
      );
   end

   always_comb begin
      rsp_word_in.chain_out_ab = {stage_data[ROUNDS].h[0] + stage_data[ROUNDS].a,
                                  stage_data[ROUNDS].h[1] + stage_data[ROUNDS].b};
      rsp_word_in.chain_out_cd = {stage_data[ROUNDS].h[2] + stage_data[ROUNDS].c,
                                  stage_data[ROUNDS].h[3] + stage_data[ROUNDS].d};
      rsp_word_in.chain_out_e  = stage_data[ROUNDS].h[4] + stage_data[ROUNDS].e;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_valid[ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A frozen pipeline must hold its valid bits in place.
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(entry_valid_ff) && $stable(stage_valid[ROUNDS / 2])
                   && $stable(stage_valid[ROUNDS]))
      else $error("pipeline valid bits moved while stalled");

   a_last_round_to_rsp: assert property (@(posedge clock) disable iff (reset)
      advance && stage_valid[ROUNDS] |=> rsp_valid_ff)
      else $error("last round word did not reach the output register");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> entry_valid_ff)
      else $error("accepted word missing from entry stage");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled with an empty output register");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !entry_valid_ff)
      else $error("valid bits survived reset");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the pipelined SHA-1 block compression unit.
module testbench;
   import sha1c_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BLOCKS = 540;
   localparam int unsigned DRAIN_AT_BLOCK = 450;
   localparam int unsigned SETTLE_CYCLES = 100;

   localparam logic [63:0] IV_AB = 64'h67452301_efcdab89;
   localparam logic [63:0] IV_CD = 64'h98badcfe_10325476;
   localparam logic [31:0] IV_E = 32'hc3d2e1f0;
   localparam req_word_type ALL_ONES = '1;

   typedef struct {
      req_word_type block;
      bit           known;
      rsp_word_type digest;
   } vector_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   rsp_word_type pending_digests[$];
   int unsigned  digests_seen = 0;
   int unsigned  error_count = 0;

   sha1_block_compress dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("testbench failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   // Expected chaining value after 80 rounds over one message block.
   function automatic rsp_word_type sha1_compress(input req_word_type blk);
      logic [7:0][63:0]  msg;
      logic [15:0][31:0] sched;
      logic [31:0]       a, b, c, d, e, f, k, wt, x, tmp;
      rsp_word_type      digest;
      msg = {blk.words_00_01, blk.words_02_03, blk.words_04_05, blk.words_06_07,
             blk.words_08_09, blk.words_10_11, blk.words_12_13, blk.words_14_15};
      for (int i = 0; i < 8; i++) begin
         sched[2*i]   = msg[7-i][63:32];
         sched[2*i+1] = msg[7-i][31:0];
      end
      a = blk.chain_in_ab[63:32];
      b = blk.chain_in_ab[31:0];
      c = blk.chain_in_cd[63:32];
      d = blk.chain_in_cd[31:0];
      e = blk.chain_in_e;
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wt = sched[r];
         end else begin
            // The schedule window wraps, so slot r mod 16 still holds word r-16.
            x = sched[(r-3)&15] ^ sched[(r-8)&15] ^ sched[(r-14)&15] ^ sched[r&15];
            wt = {x[30:0], x[31]};
            sched[r&15] = wt;
         end
         if (r < 20) begin
            f = d ^ (b & (c ^ d));
            k = K_CHOOSE;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K_PARITY_LO;
         end else if (r < 60) begin
            f = (b & c) | (d & (b ^ c));
            k = K_MAJORITY;
         end else begin
            f = b ^ c ^ d;
            k = K_PARITY_HI;
         end
         tmp = {a[26:0], a[31:27]} + f + e + k + wt;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = tmp;
      end
      digest.chain_out_ab = {blk.chain_in_ab[63:32] + a, blk.chain_in_ab[31:0] + b};
      digest.chain_out_cd = {blk.chain_in_cd[63:32] + c, blk.chain_in_cd[31:0] + d};
      digest.chain_out_e  = blk.chain_in_e + e;
      return digest;
   endfunction

   // Mostly fully random blocks, with some built from a mix of zero, all-ones,
   // one-hot and random words, and some that are all zero except for one set bit.
   function automatic req_word_type make_random_block();
      logic [20:0][31:0] w;
      int unsigned       mode;
      mode = $urandom_range(99);
      for (int i = 0; i < 21; i++) begin
         if (mode < 70) begin
            w[i] = $urandom;
         end else if (mode < 85) begin
            case ($urandom_range(3))
               0: w[i] = '0;
               1: w[i] = '1;
               2: w[i] = 32'h1 << $urandom_range(31);
               default: w[i] = $urandom;
            endcase
         end else begin
            w[i] = '0;
         end
      end
      if (mode >= 85)
         w[$urandom_range(20)][$urandom_range(31)] = 1'b1;
      return req_word_type'(w);
   endfunction

   // Sender: directed rows first, then random blocks.
   initial begin
      vector_row_type vectors[$];
      req_word_type   blk;
      rsp_word_type   want;
      int unsigned    total;

      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;

      vectors.push_back(vector_row_type'{req_word_type'('0), 1'b0, rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{ALL_ONES, 1'b0, rsp_word_type'('0)});
      // Padded "abc" and the padded empty message, both from the standard IV.
      vectors.push_back(vector_row_type'{
         req_word_type'({64'h61626380_00000000, {6{64'h0}}, 64'h00000000_00000018,
                         IV_AB, IV_CD, IV_E}),
         1'b1,
         rsp_word_type'({64'ha9993e36_4706816a, 64'hba3e2571_7850c26c, 32'h9cd0d89d})});
      vectors.push_back(vector_row_type'{
         req_word_type'({64'h80000000_00000000, {7{64'h0}}, IV_AB, IV_CD, IV_E}),
         1'b1,
         rsp_word_type'({64'hda39a3ee_5e6b4b0d, 64'h3255bfef_95601890, 32'hafd80709})});
      vectors.push_back(vector_row_type'{req_word_type'({{8{64'h0}}, IV_AB, IV_CD, IV_E}),
                                         1'b0, rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({21{32'haaaa5555}}), 1'b0,
                                         rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({21{32'h5555aaaa}}), 1'b0,
                                         rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({512'h0, {160{1'b1}}}), 1'b0,
                                         rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({{512{1'b1}}, 160'h0}), 1'b0,
                                         rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{
         req_word_type'({64'h80000000_00000000, {7{64'h0}}, 160'h0}), 1'b0,
         rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({{7{64'h0}}, 64'h1, 160'h0}),
                                         1'b0, rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({512'h0, 128'h0, 32'hffffffff}),
                                         1'b0, rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({{16{32'h80000001}}, 160'h0}),
                                         1'b0, rsp_word_type'('0)});
      vectors.push_back(vector_row_type'{req_word_type'({512'h0, {5{32'h00000001}}}),
                                         1'b0, rsp_word_type'('0)});

      total = vectors.size() + RANDOM_BLOCKS;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int unsigned i = 0; i < total; i++) begin
         if (i < vectors.size()) begin
            blk = vectors[i].block;
            want = vectors[i].known ? vectors[i].digest : sha1_compress(blk);
         end else begin
            blk = make_random_block();
            want = sha1_compress(blk);
         end
         @(negedge clock);
         if (i == DRAIN_AT_BLOCK) begin
            req_valid <= 1'b0;
            wait (pending_digests.size() == 0);
            @(negedge clock);
         end
         // No idle cycles for a stretch of blocks in the middle of the run.
         while (!(i >= 250 && i < 370) && $urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_word <= blk;
         @(posedge clock);
         while (req_stall)
            @(posedge clock);
         pending_digests.push_back(want);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_digests.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // Receiver back-pressure: random stalls, one long hold that fills the
   // pipeline, and a window with no stalls at all.
   initial begin
      int unsigned hold_left;
      bit          long_hold_done;
      hold_left = 0;
      long_hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!long_hold_done && digests_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left = 299;
            rsp_stall <= 1'b1;
         end else if (digests_seen >= 240 && digests_seen < 360) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 24);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         digests_seen++;
         if (pending_digests.size() == 0) begin
            report_mismatch($sformatf("result word %h with none expected", rsp_word));
         end else begin
            want = pending_digests.pop_front();
            if (rsp_word.chain_out_ab !== want.chain_out_ab)
               report_mismatch($sformatf("result %0d chain_out_ab %h, expected %h",
                                         digests_seen, rsp_word.chain_out_ab,
                                         want.chain_out_ab));
            if (rsp_word.chain_out_cd !== want.chain_out_cd)
               report_mismatch($sformatf("result %0d chain_out_cd %h, expected %h",
                                         digests_seen, rsp_word.chain_out_cd,
                                         want.chain_out_cd));
            if (rsp_word.chain_out_e !== want.chain_out_e)
               report_mismatch($sformatf("result %0d chain_out_e %h, expected %h",
                                         digests_seen, rsp_word.chain_out_e,
                                         want.chain_out_e));
         end
      end
   end

endmodule
